>>> src/occ_pkg.sv
// Package for the ordered composition counter.
// Field widths, modulus, sequencer states and the accumulator control word.
// No dependencies.
package occ_pkg;

  localparam int unsigned PART_W = 8;
  localparam int unsigned TGT_W  = 10;
  localparam int unsigned WAY_W  = 30;

  localparam logic [WAY_W-1:0] WAY_MOD = 30'd1000000007;
  localparam logic [WAY_W-1:0] WAY_ONE = 30'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctrl_t;

endpackage

>>> src/occ_if.sv
// Valid/ready channel interfaces for the ordered composition counter.
// Depends on occ_pkg for the field widths.
interface occ_in_if;
  logic                        valid;
  logic                        ready;
  logic [occ_pkg::PART_W-1:0]  part_value;
  logic                        is_last;
  logic [occ_pkg::TGT_W-1:0]   target;

  modport source (output valid, part_value, is_last, target, input ready);
  modport sink   (input valid, part_value, is_last, target, output ready);
endinterface

interface occ_out_if;
  logic                       valid;
  logic                       ready;
  logic [occ_pkg::WAY_W-1:0]  way_count;
  logic                       parts_overflow;

  modport source (output valid, way_count, parts_overflow, input ready);
  modport sink   (input valid, way_count, parts_overflow, output ready);
endinterface

>>> src/occ_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module occ_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/occ_modadd.sv
// Shared modular accumulator: cleared on clr, else acc <= (acc + operand) mod 1000000007 on add.
// Depends on occ_pkg.
module occ_modadd (
  input  logic                       clk_i,
  input  occ_pkg::acc_ctrl_t         ctrl_i,
  input  logic [occ_pkg::WAY_W-1:0]  operand_i,
  output logic [occ_pkg::WAY_W-1:0]  acc_o
);
  import occ_pkg::*;

  logic [WAY_W-1:0] acc_q, acc_d;
  logic [WAY_W:0]   sum;

  // both operands are below the modulus, so one subtract suffices
  always_comb begin
    sum = {1'b0, acc_q} + {1'b0, operand_i};
    if (sum >= {1'b0, WAY_MOD}) begin
      sum = sum - {1'b0, WAY_MOD};
    end
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = sum[WAY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

>>> src/occ_seq.sv
// Sequencer: part loading, table fill loop and result hand-off.
// Depends on occ_pkg; drives both RAMs and the shared modular accumulator.
module occ_seq #(
  parameter int unsigned MAX_PARTS  = 1024,
  parameter int unsigned MAX_TARGET = 1023,
  parameter int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1,
  parameter int unsigned TW = $clog2(MAX_TARGET + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  input  logic [occ_pkg::TGT_W-1:0]    in_target_i,
  output logic                         in_ready_o,
  output logic                         pst_we_o,
  output logic [AW-1:0]                pst_waddr_o,
  output logic                         pst_re_o,
  output logic [AW-1:0]                pst_raddr_o,
  input  logic [occ_pkg::PART_W-1:0]   pst_rdata_i,
  output logic                         way_we_o,
  output logic [TW-1:0]                way_waddr_o,
  output logic [occ_pkg::WAY_W-1:0]    way_wdata_o,
  output logic                         way_re_o,
  output logic [TW-1:0]                way_raddr_o,
  output occ_pkg::acc_ctrl_t           acc_ctrl_o,
  input  logic [occ_pkg::WAY_W-1:0]    acc_i,
  input  logic                         res_free_i,
  output logic                         res_valid_o,
  output logic [occ_pkg::WAY_W-1:0]    res_count_o,
  output logic                         res_ovf_o
);
  import occ_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PARTS + 1);
  localparam int unsigned CW = (TW > PART_W) ? TW : PART_W;

  state_e           state_q, state_d;
  logic [PW-1:0]    loaded_q, loaded_d;
  logic             ovf_q, ovf_d;
  logic [TW-1:0]    goal_q, goal_d;
  logic [TW-1:0]    i_q, i_d;
  logic [PW-1:0]    j_q, j_d;
  logic             s1_q, s1_d;
  logic             s2_q, s2_d;
  logic [WAY_W-1:0] res_q, res_d;
  logic             accept;
  logic             scan_more;
  logic             drained;
  logic             fits;
  logic [TW-1:0]    goal_sat;

  assign accept    = in_valid_i && in_ready_o;
  assign scan_more = j_q < loaded_q;
  assign drained   = !s1_q && !s2_q;
  assign fits      = (pst_rdata_i != '0) && (CW'(pst_rdata_i) <= CW'(i_q));

  always_comb begin
    if (32'(in_target_i) > 32'(MAX_TARGET)) begin
      goal_sat = TW'(MAX_TARGET);
    end else begin
      goal_sat = TW'(in_target_i);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_last_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        state_d = (goal_q == '0) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_d = (i_q == goal_q) ? ST_FIN : ST_SCAN;
        end
      end
      ST_FIN: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o     = 1'b0;
    pst_we_o       = 1'b0;
    pst_waddr_o    = loaded_q[AW-1:0];
    pst_re_o       = 1'b0;
    pst_raddr_o    = j_q[AW-1:0];
    way_we_o       = 1'b0;
    way_waddr_o    = i_q;
    way_wdata_o    = acc_i;
    way_re_o       = s1_q && fits;
    way_raddr_o    = TW'(CW'(i_q) - CW'(pst_rdata_i));
    acc_ctrl_o.clr = 1'b0;
    acc_ctrl_o.add = s2_q;
    res_valid_o    = 1'b0;
    loaded_d       = loaded_q;
    ovf_d          = ovf_q;
    goal_d         = goal_q;
    i_d            = i_q;
    j_d            = j_q;
    s1_d           = 1'b0;
    s2_d           = s1_q && fits;
    res_d          = res_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (loaded_q < PW'(MAX_PARTS)) begin
            pst_we_o = 1'b1;
            loaded_d = loaded_q + PW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            goal_d = goal_sat;
          end
        end
      end
      ST_INIT: begin
        way_we_o       = 1'b1;
        way_waddr_o    = '0;
        way_wdata_o    = WAY_ONE;
        acc_ctrl_o.clr = 1'b1;
        i_d            = TW'(1);
        j_d            = '0;
        res_d          = WAY_ONE;
      end
      ST_SCAN: begin
        if (scan_more) begin
          pst_re_o = 1'b1;
          s1_d     = 1'b1;
          j_d      = j_q + PW'(1);
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          way_we_o       = 1'b1;
          acc_ctrl_o.clr = 1'b1;
          res_d          = acc_i;
          i_d            = i_q + TW'(1);
          j_d            = '0;
        end
      end
      ST_FIN: begin
        res_valid_o = res_free_i;
        if (res_free_i) begin
          loaded_d = '0;
          ovf_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_count_o = res_q;
  assign res_ovf_o   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
      ovf_q    <= 1'b0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      ovf_q    <= ovf_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    goal_q <= goal_d;
    i_q    <= i_d;
    j_q    <= j_d;
    res_q  <= res_d;
  end

endmodule

>>> src/ordered_composition_counter.sv
// Ordered composition counter: counts ordered sums of loaded parts, mod 1e9+7.
// Depends on occ_pkg, occ_if, occ_ram, occ_modadd and occ_seq.
//
// in_i  : one part_value word per handshake, taken one per cycle while loading.
//         The word with is_last set also carries target (saturated to
//         MAX_TARGET) and starts the count; no result for other words.
// out_o : one word per count: way_count and parts_overflow (parts beyond
//         MAX_PARTS were dropped). Held in an output register until taken.
// Count: each table entry up to target T needs N reads of the part store
//   (N loaded parts) through its single read port, a two-stage read pipeline
//   into the way table, and one shared modular adder; in_i is not ready
//   meanwhile.
// Stall: if out_o still holds an untaken word when a count ends, the block
//   waits with the result until the register frees.
// Reset: asynchronous, active low; clears the part count, overflow flag and
//   output valid. RAM contents need no clearing: only written entries are read.
module ordered_composition_counter #(
  parameter int unsigned MAX_PARTS  = 1024,
  parameter int unsigned MAX_TARGET = 1023
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  occ_in_if.sink           in_i,
  occ_out_if.source        out_o
);
  import occ_pkg::*;

  localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned TW = $clog2(MAX_TARGET + 1);

  logic              pst_we, pst_re;
  logic [AW-1:0]     pst_waddr, pst_raddr;
  logic [PART_W-1:0] pst_rdata;
  logic              way_we, way_re;
  logic [TW-1:0]     way_waddr, way_raddr;
  logic [WAY_W-1:0]  way_wdata, way_rdata;
  acc_ctrl_t         acc_ctrl;
  logic [WAY_W-1:0]  acc;
  logic              res_free, res_valid, res_ovf;
  logic [WAY_W-1:0]  res_count;
  logic              out_valid_q;
  logic [WAY_W-1:0]  out_count_q;
  logic              out_ovf_q;

  occ_ram #(
    .WIDTH (PART_W),
    .DEPTH (MAX_PARTS)
  ) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (pst_we),
    .waddr_i (pst_waddr),
    .wdata_i (in_i.part_value),
    .re_i    (pst_re),
    .raddr_i (pst_raddr),
    .rdata_o (pst_rdata)
  );

  occ_ram #(
    .WIDTH (WAY_W),
    .DEPTH (MAX_TARGET + 1)
  ) u_way_ram (
    .clk_i   (clk_i),
    .we_i    (way_we),
    .waddr_i (way_waddr),
    .wdata_i (way_wdata),
    .re_i    (way_re),
    .raddr_i (way_raddr),
    .rdata_o (way_rdata)
  );

  occ_modadd u_modadd (
    .clk_i     (clk_i),
    .ctrl_i    (acc_ctrl),
    .operand_i (way_rdata),
    .acc_o     (acc)
  );

  occ_seq #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_TARGET (MAX_TARGET),
    .AW         (AW),
    .TW         (TW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.is_last),
    .in_target_i (in_i.target),
    .in_ready_o  (in_i.ready),
    .pst_we_o    (pst_we),
    .pst_waddr_o (pst_waddr),
    .pst_re_o    (pst_re),
    .pst_raddr_o (pst_raddr),
    .pst_rdata_i (pst_rdata),
    .way_we_o    (way_we),
    .way_waddr_o (way_waddr),
    .way_wdata_o (way_wdata),
    .way_re_o    (way_re),
    .way_raddr_o (way_raddr),
    .acc_ctrl_o  (acc_ctrl),
    .acc_i       (acc),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_count_o (res_count),
    .res_ovf_o   (res_ovf)
  );

  assign res_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_count_q <= res_count;
      out_ovf_q   <= res_ovf;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.way_count      = out_count_q;
  assign out_o.parts_overflow = out_ovf_q;

endmodule

>>> sim/occ_checker.sv
`timescale 1ns / 100ps
// Checker for the ordered composition counter: watches both channels,
// predicts each count from the part words seen and compares. Uses occ_pkg, occ_if.
module occ_checker #(
  parameter int unsigned MAX_PARTS  = 1024,
  parameter int unsigned MAX_TARGET = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  occ_in_if           in_w,
  occ_out_if          out_w,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned counts_done_o
);
  import occ_pkg::*;

  typedef struct packed {
    logic [WAY_W-1:0] way_count;
    logic             parts_overflow;
  } count_word_t;

  logic [PART_W-1:0] held_parts[$];
  logic              dropped = 1'b0;
  count_word_t       awaited[$];
  int unsigned       fails = 0;
  int unsigned       counts_done = 0;

  assign fail_count_o  = fails;
  assign pending_o     = awaited.size();
  assign counts_done_o = counts_done;

  // way table built bottom up; zero parts never contribute
  function automatic logic [WAY_W-1:0] ways_to(input int unsigned goal);
    logic [WAY_W-1:0] tbl [0:MAX_TARGET];
    logic [WAY_W:0]   acc;
    int unsigned      p;
    tbl[0] = WAY_ONE;
    for (int unsigned i = 1; i <= goal; i++) begin
      acc = '0;
      foreach (held_parts[j]) begin
        p = held_parts[j];
        if (p != 0 && p <= i) begin
          acc = acc + tbl[i - p];
          if (acc >= WAY_MOD) acc = acc - WAY_MOD;
        end
      end
      tbl[i] = acc[WAY_W-1:0];
    end
    return tbl[goal];
  endfunction

  always @(posedge clk_i) begin
    int unsigned goal;
    count_word_t want;
    if (rst_ni) begin
      if (in_w.valid && in_w.ready) begin
        if (held_parts.size() < MAX_PARTS) held_parts.push_back(in_w.part_value);
        else dropped = 1'b1;
        if (in_w.is_last) begin
          goal = in_w.target;
          if (goal > MAX_TARGET) goal = MAX_TARGET;
          want.way_count      = ways_to(goal);
          want.parts_overflow = dropped;
          awaited.push_back(want);
          held_parts.delete();
          dropped = 1'b0;
        end
      end
      if (out_w.valid && out_w.ready) begin
        if (awaited.size() == 0) begin
          $error("unexpected count word: way_count %0d, parts_overflow %0b",
                 out_w.way_count, out_w.parts_overflow);
          fails++;
        end else begin
          want = awaited.pop_front();
          counts_done++;
          if (out_w.way_count !== want.way_count) begin
            $error("way_count: expected %0d, actual %0d", want.way_count, out_w.way_count);
            fails++;
          end
          if (out_w.parts_overflow !== want.parts_overflow) begin
            $error("parts_overflow: expected %0b, actual %0b",
                   want.parts_overflow, out_w.parts_overflow);
            fails++;
          end
        end
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the ordered composition counter bench: clock, reset, part word
// stimulus and output back-pressure. Uses occ_pkg, occ_if and occ_checker.
module testbench;
  import occ_pkg::*;

  localparam int unsigned MAX_PARTS  = 1024;
  localparam int unsigned MAX_TARGET = 1023;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  occ_in_if  in_w ();
  occ_out_if out_w ();

  ordered_composition_counter #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_TARGET (MAX_TARGET)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  int unsigned fail_count, pending, counts_done;

  occ_checker #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_TARGET (MAX_TARGET)
  ) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_w          (in_w),
    .out_w         (out_w),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .counts_done_o (counts_done)
  );

  bit          steady    = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [PART_W-1:0] part, input logic last,
                           input logic [TGT_W-1:0] tgt);
    while (!steady && $urandom_range(99) < 32) begin
      in_w.valid      <= 1'b0;
      in_w.part_value <= PART_W'($urandom);
      in_w.target     <= TGT_W'($urandom);
      @(negedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.part_value <= part;
    in_w.is_last    <= last;
    in_w.target     <= last ? tgt : TGT_W'($urandom);
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_set(input logic [PART_W-1:0] parts[$], input logic [TGT_W-1:0] tgt);
    foreach (parts[i]) send_word(parts[i], i == parts.size() - 1, tgt);
  endtask

  function automatic logic [PART_W-1:0] pick_part();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return PART_W'($urandom_range(1, 6));
    if (r < 92) return PART_W'($urandom);
    return (r < 96) ? 8'd0 : 8'd255;
  endfunction

  // receiver: one long hold-off once asked, random stalls otherwise
  initial begin
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_w.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 1500;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    logic [PART_W-1:0] q[$];
    int unsigned       n, tgt, rand_words;
    bit                paused;
    in_w.valid      = 1'b0;
    in_w.part_value = '0;
    in_w.is_last    = 1'b0;
    in_w.target     = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    q = {8'd5};                 send_set(q, 10'd0);
    q = {8'd1};                 send_set(q, 10'd1);
    q = {8'd0};                 send_set(q, 10'd7);
    q = {8'd1, 8'd1};           send_set(q, 10'd3);
    q = {8'd255};               send_set(q, 10'd255);
    q = {8'd1, 8'd255};         send_set(q, 10'd1023);
    q = {8'd1, 8'd2, 8'd3};     send_set(q, 10'd1023);
    q = {8'd0, 8'd2};           send_set(q, 10'd10);
    q = {8'd3, 8'd7, 8'd170};   send_set(q, 10'd682);
    q = {8'd2, 8'd5, 8'd85};    send_set(q, 10'd341);
    q = {8'd4, 8'd4, 8'd0};     send_set(q, 10'd12);

    // store depth: filled, then several words dropped including the last
    q.delete();
    repeat (MAX_PARTS + 3) q.push_back(pick_part());
    send_set(q, 10'd3);

    hold_req   = 1'b1;
    rand_words = 0;
    paused     = 1'b0;
    while (rand_words < 950) begin
      n = ($urandom_range(11) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      tgt = ($urandom_range(39) == 0) ? $urandom_range(512, 1023) : $urandom_range(0, 40);
      q.delete();
      repeat (n) q.push_back(pick_part());
      steady = (rand_words >= 200 && rand_words < 450);
      send_set(q, TGT_W'(tgt));
      rand_words += n;
      if (!paused && rand_words >= 600) begin
        paused = 1'b1;
        in_w.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
    end
    steady = 1'b0;
    in_w.valid <= 1'b0;

    wait (pending == 0);
    repeat (64) @(posedge clk_i);
    $display("covered %0d part words and %0d checked counts: zero and full-range parts,",
             words_sent, counts_done);
    $display("targets up to 1023, a store filled past its depth, a long output stall");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
